// ===== rtl/gfq_pkg.sv =====
// ----------------------------------------------------------------------------
// gfq_pkg
// Shared types, constants and helpers of the group fake-quantize unit.
// ----------------------------------------------------------------------------
package gfq_pkg;

   // quantization bit-width register
   localparam int QBITS_W = 4;
   localparam logic [QBITS_W-1:0] QBITS_RESET = 4'd6;
   localparam logic [QBITS_W-1:0] QBITS_MIN = 4'd1;
   localparam logic [QBITS_W-1:0] QBITS_MAX = 4'd8;
   localparam int LEVEL_BITS = 8;

   // lane sequencer
   typedef enum logic [2:0] {
      LN_IDLE,
      LN_DIV1S,
      LN_DIV1,
      LN_MUL2,
      LN_DIV2S,
      LN_DIV2
   } lane_state_type;

   // group sequencer
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RANGE,
      ST_ZERO,
      ST_ZWAIT,
      ST_READ,
      ST_START,
      ST_WAIT,
      ST_EMIT
   } seq_state_type;

   // command into a lane
   typedef struct packed {
      logic start;
      logic zero_mode;
      logic keep;
   } lane_cmd_type;

   // status out of a lane
   typedef struct packed {
      logic busy;
   } lane_stat_type;

   // levels = 2^bits - 1, bits clamped to 1..8
   function automatic logic [LEVEL_BITS-1:0] levels_of(input logic [QBITS_W-1:0] qb);
      logic [QBITS_W-1:0] b;
      logic [LEVEL_BITS:0] v;
      begin
         if (qb < QBITS_MIN) begin
            b = QBITS_MIN;
         end else if (qb > QBITS_MAX) begin
            b = QBITS_MAX;
         end else begin
            b = qb;
         end
         v = ((LEVEL_BITS + 1)'(1) << b) - (LEVEL_BITS + 1)'(1);
         levels_of = v[LEVEL_BITS-1:0];
      end
   endfunction

endpackage

// ===== rtl/gfq_div.sv =====
// ----------------------------------------------------------------------------
// gfq_div
// Restoring unsigned divider, one quotient bit per cycle, result rounded
// to nearest with halves up.
// ----------------------------------------------------------------------------
module gfq_div #(
   parameter int NW = 24,
   parameter int DW = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          busy,
   output logic [NW-1:0] quot
);

   localparam int CW = $clog2(NW + 1);

   logic          busy_ff;
   logic [CW-1:0] cnt_ff;
   logic [NW-1:0] num_ff;
   logic [DW-1:0] den_ff;
   logic [DW-1:0] rem_ff;
   logic [NW-1:0] quo_ff;

   logic [DW:0]   trial;
   logic          fits;
   logic          round_up;

   // one restoring step
   assign trial = {rem_ff, num_ff[NW-1]};
   assign fits  = (trial >= {1'b0, den_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && (cnt_ff == CW'(1))) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff <= CW'(NW);
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff - CW'(1);
         num_ff <= {num_ff[NW-2:0], 1'b0};
         rem_ff <= fits ? DW'(trial - {1'b0, den_ff}) : DW'(trial);
         quo_ff <= {quo_ff[NW-2:0], fits};
      end
   end

   // round half up on the remainder
   assign round_up = ({1'b0, rem_ff, 1'b0} >= {2'b0, den_ff});
   assign quot     = quo_ff + NW'(round_up);
   assign busy     = busy_ff;

endmodule

// ===== rtl/gfq_lane.sv =====
// ----------------------------------------------------------------------------
// gfq_lane
// One fake-quantize lane: quantize one sample to the group's levels and
// dequantize it back, or compute the group zero point.
// ----------------------------------------------------------------------------
module gfq_lane #(
   parameter int S = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  gfq_pkg::lane_cmd_type     cmd,
   input  logic signed [S-1:0]       x,
   input  logic [7:0]                levels,
   input  logic [S-1:0]              range,
   input  logic [7:0]                zero,
   output gfq_pkg::lane_stat_type    stat,
   output logic signed [S-1:0]       res,
   output logic [7:0]                zero_out
);

   localparam int NW = S + 8;
   localparam int TW = S + 10;
   localparam logic signed [TW-1:0] SMAX_T = {11'b0, {(S-1){1'b1}}};
   localparam logic signed [TW-1:0] SMIN_T = {{11{1'b1}}, {(S-1){1'b0}}};

   gfq_pkg::lane_state_type state_ff, state_in;

   logic                 neg_ff;
   logic [NW-1:0]        mag_ff;
   logic signed [8:0]    d_ff;
   logic signed [S-1:0]  res_ff;
   logic [7:0]           zero_out_ff;

   logic signed [S+8:0]  p1;
   logic signed [S+9:0]  p2;
   logic                 div_start;
   logic [S-1:0]         div_den;
   logic                 div_busy;
   logic [NW-1:0]        div_q;
   logic signed [TW-1:0] sr;
   logic signed [TW-1:0] zr;
   logic signed [TW-1:0] t;
   logic [7:0]           qv;
   logic signed [S-1:0]  sat;

   // shared divider: by range first, then by levels
   assign div_start = (state_ff == gfq_pkg::LN_DIV1S) || (state_ff == gfq_pkg::LN_DIV2S);
   assign div_den   = (state_ff == gfq_pkg::LN_DIV1S) ? range : S'(levels);

   gfq_div #(.NW(NW), .DW(S)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (mag_ff),
      .den   (div_den),
      .busy  (div_busy),
      .quot  (div_q)
   );

   // products
   assign p1 = x * $signed({1'b0, levels});
   assign p2 = d_ff * $signed({1'b0, range});

   // signed quotient and its uses
   always_comb begin
      sr = neg_ff ? -$signed({2'b0, div_q}) : $signed({2'b0, div_q});
      zr = -sr;
      t  = sr + $signed({{(S+2){1'b0}}, zero});
      if (t < 0) begin
         qv = 8'd0;
      end else if (t > $signed({{(S+2){1'b0}}, levels})) begin
         qv = levels;
      end else begin
         qv = t[7:0];
      end
      if (sr > SMAX_T) begin
         sat = SMAX_T[S-1:0];
      end else if (sr < SMIN_T) begin
         sat = SMIN_T[S-1:0];
      end else begin
         sat = sr[S-1:0];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gfq_pkg::LN_IDLE: begin
            if (cmd.start && !cmd.keep) state_in = gfq_pkg::LN_DIV1S;
         end
         gfq_pkg::LN_DIV1S: state_in = gfq_pkg::LN_DIV1;
         gfq_pkg::LN_DIV1: begin
            if (!div_busy) state_in = cmd.zero_mode ? gfq_pkg::LN_IDLE : gfq_pkg::LN_MUL2;
         end
         gfq_pkg::LN_MUL2:  state_in = gfq_pkg::LN_DIV2S;
         gfq_pkg::LN_DIV2S: state_in = gfq_pkg::LN_DIV2;
         gfq_pkg::LN_DIV2: begin
            if (!div_busy) state_in = gfq_pkg::LN_IDLE;
         end
         default: state_in = gfq_pkg::LN_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfq_pkg::LN_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // zero mode is held by the caller for the whole computation
   always_ff @(posedge clock) begin
      case (state_ff)
         gfq_pkg::LN_IDLE: begin
            if (cmd.start) begin
               res_ff <= x;
               neg_ff <= p1[S+8];
               mag_ff <= p1[S+8] ? NW'(-p1) : NW'(p1);
            end
         end
         gfq_pkg::LN_DIV1: begin
            if (!div_busy) begin
               if (zr < 0) begin
                  zero_out_ff <= 8'd0;
               end else if (zr > $signed({{(S+2){1'b0}}, levels})) begin
                  zero_out_ff <= levels;
               end else begin
                  zero_out_ff <= zr[7:0];
               end
               d_ff <= $signed({1'b0, qv}) - $signed({1'b0, zero});
            end
         end
         gfq_pkg::LN_MUL2: begin
            neg_ff <= p2[S+9];
            mag_ff <= p2[S+9] ? NW'(-p2) : NW'(p2);
         end
         gfq_pkg::LN_DIV2: begin
            if (!div_busy) res_ff <= sat;
         end
         default: begin
         end
      endcase
   end

   assign stat.busy = (state_ff != gfq_pkg::LN_IDLE);
   assign res       = res_ff;
   assign zero_out  = zero_out_ff;

endmodule

// ===== rtl/group_fake_quantize_activations_unit.sv =====
// ----------------------------------------------------------------------------
// group_fake_quantize_activations_unit
// Asymmetric group fake-quantizer for signed activation pairs.
// ----------------------------------------------------------------------------
// Items are taken one pair per cycle until a group of GROUP_SIZE/2 pairs is
// stored; intake then stops while the group is emitted in arrival order.
// Emission first computes the zero point on one lane, then each pair goes
// through two lanes in parallel, each doing two bit-serial divisions of
// SAMPLE_BITS+8 steps, and the pair then waits on any output stall; a pair
// with both samples salient skips the divisions, otherwise a salient sample
// waits for its partner lane. The lane dividers set the rate. quant_bits is
// sampled when a group fills.
// ----------------------------------------------------------------------------
module group_fake_quantize_activations_unit #(
   parameter int GROUP_SIZE  = 128,
   parameter int SAMPLE_BITS = 16
) (
   input  logic clock,
   input  logic reset,
   // sample_a, sample_b (from bit 0 up)
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0] req_tdata,
   // keep_a, keep_b (from bit 0 up)
   input  logic [1:0]                         req_tuser,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // value_a, value_b (from bit 0 up)
   output logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic                               csr_wen,
   input  logic [gfq_pkg::QBITS_W-1:0]        csr_wdata
);

   localparam int S     = SAMPLE_BITS;
   localparam int PAIRS = GROUP_SIZE / 2;
   localparam int AW    = $clog2(PAIRS);
   localparam int EW    = 2 * S + 2;
   localparam int TDW   = ((2 * S + 7) / 8) * 8;

   gfq_pkg::seq_state_type state_ff, state_in;

   logic [EW-1:0]              mem [PAIRS];
   logic [EW-1:0]              rd_data_ff;
   logic [AW-1:0]              cnt_ff;
   logic [AW-1:0]              rd_idx_ff;
   logic signed [S-1:0]        min_ff;
   logic signed [S-1:0]        max_ff;
   logic [gfq_pkg::QBITS_W-1:0] qbits_ff;
   logic [7:0]                 levels_ff;
   logic [S-1:0]               range_ff;
   logic [7:0]                 zero_ff;
   logic                       rsp_valid_ff;
   logic signed [S-1:0]        va_ff;
   logic signed [S-1:0]        vb_ff;
   logic                       last_ff;

   logic                       in_acc;
   logic signed [S-1:0]        in_a;
   logic signed [S-1:0]        in_b;
   logic signed [S-1:0]        lo;
   logic signed [S-1:0]        hi;
   logic                       load_last;
   logic                       emit_last;
   logic                       slot_free;
   logic signed [S:0]          diff;
   gfq_pkg::lane_cmd_type      cmd_a, cmd_b;
   gfq_pkg::lane_stat_type     stat_a, stat_b;
   logic signed [S-1:0]        x_a;
   logic signed [S-1:0]        res_a, res_b;
   logic [7:0]                 zero_a;

   assign in_acc    = req_tvalid && req_tready;
   assign in_a      = req_tdata[S-1:0];
   assign in_b      = req_tdata[2*S-1:S];
   assign lo        = (in_a < in_b) ? in_a : in_b;
   assign hi        = (in_a < in_b) ? in_b : in_a;
   assign load_last = (cnt_ff == AW'(PAIRS - 1));
   assign emit_last = (rd_idx_ff == AW'(PAIRS - 1));
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign diff      = {max_ff[S-1], max_ff} - {min_ff[S-1], min_ff};

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         qbits_ff <= gfq_pkg::QBITS_RESET;
      end else if (csr_wen) begin
         qbits_ff <= csr_wdata;
      end
   end

   // group sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         gfq_pkg::ST_LOAD: begin
            if (in_acc && load_last) state_in = gfq_pkg::ST_RANGE;
         end
         gfq_pkg::ST_RANGE: state_in = gfq_pkg::ST_ZERO;
         gfq_pkg::ST_ZERO:  state_in = gfq_pkg::ST_ZWAIT;
         gfq_pkg::ST_ZWAIT: begin
            if (!stat_a.busy) state_in = gfq_pkg::ST_READ;
         end
         gfq_pkg::ST_READ:  state_in = gfq_pkg::ST_START;
         gfq_pkg::ST_START: state_in = gfq_pkg::ST_WAIT;
         gfq_pkg::ST_WAIT: begin
            if (!stat_a.busy && !stat_b.busy) state_in = gfq_pkg::ST_EMIT;
         end
         gfq_pkg::ST_EMIT: begin
            if (slot_free) state_in = emit_last ? gfq_pkg::ST_LOAD : gfq_pkg::ST_READ;
         end
         default: state_in = gfq_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gfq_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == gfq_pkg::ST_LOAD);

   // pair store
   always_ff @(posedge clock) begin
      if (in_acc) mem[cnt_ff] <= {req_tuser[1], req_tuser[0], in_b, in_a};
      rd_data_ff <= mem[rd_idx_ff];
   end

   // fill and read counters
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         rd_idx_ff <= '0;
      end else begin
         if (in_acc) cnt_ff <= load_last ? '0 : cnt_ff + AW'(1);
         if ((state_ff == gfq_pkg::ST_EMIT) && slot_free) begin
            rd_idx_ff <= emit_last ? '0 : rd_idx_ff + AW'(1);
         end
      end
   end

   // group statistics
   always_ff @(posedge clock) begin
      if (in_acc) begin
         if (cnt_ff == '0) begin
            min_ff <= lo;
            max_ff <= hi;
         end else begin
            if (lo < min_ff) min_ff <= lo;
            if (hi > max_ff) max_ff <= hi;
         end
         if (load_last) levels_ff <= gfq_pkg::levels_of(qbits_ff);
      end
      if (state_ff == gfq_pkg::ST_RANGE) begin
         range_ff <= (diff == '0) ? S'(1) : diff[S-1:0];
      end
      if ((state_ff == gfq_pkg::ST_ZWAIT) && !stat_a.busy) zero_ff <= zero_a;
   end

   // lane commands
   always_comb begin
      cmd_a.zero_mode = (state_ff == gfq_pkg::ST_ZERO) || (state_ff == gfq_pkg::ST_ZWAIT);
      cmd_a.start     = (state_ff == gfq_pkg::ST_ZERO) || (state_ff == gfq_pkg::ST_START);
      cmd_a.keep      = (state_ff == gfq_pkg::ST_START) && rd_data_ff[2*S];
      cmd_b.zero_mode = 1'b0;
      cmd_b.start     = (state_ff == gfq_pkg::ST_START);
      cmd_b.keep      = rd_data_ff[2*S+1];
      x_a             = (state_ff == gfq_pkg::ST_ZERO) ? min_ff : rd_data_ff[S-1:0];
   end

   gfq_lane #(.S(S)) u_lane_a (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_a),
      .x        (x_a),
      .levels   (levels_ff),
      .range    (range_ff),
      .zero     (zero_ff),
      .stat     (stat_a),
      .res      (res_a),
      .zero_out (zero_a)
   );

   // lane b never computes the zero point
   gfq_lane #(.S(S)) u_lane_b (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd_b),
      .x        (rd_data_ff[2*S-1:S]),
      .levels   (levels_ff),
      .range    (range_ff),
      .zero     (zero_ff),
      .stat     (stat_b),
      .res      (res_b),
      .zero_out ()
   );

   // merge lanes into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == gfq_pkg::ST_EMIT) && slot_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == gfq_pkg::ST_EMIT) && slot_free) begin
         va_ff   <= res_a;
         vb_ff   <= res_b;
         last_ff <= emit_last;
      end
   end

   assign rsp_tdata  = TDW'({vb_ff, va_ff});
   assign rsp_tlast  = last_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/gfq_checker.sv =====
// ----------------------------------------------------------------------------
// gfq_checker
// Port-level checks of the group fake-quantize unit, bound to the top level.
// ----------------------------------------------------------------------------
module gfq_checker #(
   parameter int GROUP_SIZE  = 128,
   parameter int SAMPLE_BITS = 16
) (
   input logic clock,
   input logic reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [((2*SAMPLE_BITS+7)/8)*8-1:0] rsp_tdata,
   input logic                               rsp_tlast,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready
);

   localparam int PAIRS = GROUP_SIZE / 2;
   localparam int AW    = $clog2(PAIRS);

   logic [AW-1:0] in_cnt_ff;
   logic [AW-1:0] out_cnt_ff;
   logic [1:0]    pend_ff;
   logic          in_acc;
   logic          out_acc;
   logic          grp_in;
   logic          grp_out;

   assign in_acc  = req_tvalid && req_tready;
   assign out_acc = rsp_tvalid && rsp_tready;
   assign grp_in  = in_acc && (in_cnt_ff == AW'(PAIRS - 1));
   assign grp_out = out_acc && rsp_tlast;

   // item and group bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= '0;
         out_cnt_ff <= '0;
         pend_ff    <= '0;
      end else begin
         if (in_acc) in_cnt_ff <= (in_cnt_ff == AW'(PAIRS - 1)) ? '0 : in_cnt_ff + AW'(1);
         if (out_acc) out_cnt_ff <= (out_cnt_ff == AW'(PAIRS - 1)) ? '0 : out_cnt_ff + AW'(1);
         pend_ff <= pend_ff + 2'(grp_in) - 2'(grp_out);
      end
   end

   // group end marks exactly the last pair of each group
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      out_acc |-> (rsp_tlast == (out_cnt_ff == AW'(PAIRS - 1))))
      else $error("group end out of place");

   // no result before its group is complete
   a_no_early: assert property (@(posedge clock) disable iff (reset)
      out_acc |-> (pend_ff != 2'd0))
      else $error("result without a complete group");

   // intake only while at most the final pair of a group is still pending
   a_intake: assert property (@(posedge clock) disable iff (reset)
      (req_tready && (pend_ff != 2'd0)) |-> (rsp_tvalid && rsp_tlast))
      else $error("intake while a group is being emitted");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("stalled result changed");

endmodule

bind group_fake_quantize_activations_unit gfq_checker #(
   .GROUP_SIZE  (GROUP_SIZE),
   .SAMPLE_BITS (SAMPLE_BITS)
) u_gfq_checker (.*);
